// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define RFAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rfam assertion failed");

// Next-cycle implication, off during reset.
`define RFAM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rfam assertion failed");

// Next-cycle implication, also checked through reset.
`define RFAM_ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rfam assertion failed");

`endif

// ----- hdl/rfam_pkg.sv -----
// Package for the radial feather alpha mask: item types, register codes,
// fixed-point constants and the square-root step. No dependencies.
`timescale 1ns / 1ps

package rfam_pkg;

    localparam int SQRT_STAGES     = 8;
    localparam int SQRT_ITER_STAGE = 2;

    localparam logic [8:0]  MAX_CANVAS = 9'd256;
    localparam logic [14:0] OUTER_MIN  = 15'd256;
    localparam logic [24:0] ONE_Q24    = 25'h100_0000;
    localparam logic [32:0] HALF_Q24   = 33'h0_0080_0000;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_OUTER_RADIUS = 2'd0;
    localparam t_cfg_index CFG_INNER_RADIUS = 2'd1;
    localparam t_cfg_index CFG_RAMP_GAIN    = 2'd2;

    localparam logic [14:0] OUTER_RESET = 15'd256;
    localparam logic [14:0] INNER_RESET = 15'd0;
    localparam logic [24:0] GAIN_RESET  = 25'd65536;

    typedef struct packed {
        logic        off;
        logic [31:0] colour;
        logic [31:0] sq_sum;
    } t_dist_item;

    typedef struct packed {
        logic        off;
        logic [31:0] colour;
        logic [15:0] root;
    } t_root_item;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] root;
    } t_sqrt_state;

    typedef struct packed {
        logic        off;
        logic [31:0] colour;
        t_sqrt_state st;
    } t_sqrt_item;

    // One digit of the restoring integer square root; step k tests bit 30-2k.
    function automatic t_sqrt_state sqrt_step(t_sqrt_state s, logic [3:0] k);
        logic [4:0]  sh;
        logic [31:0] bitv;
        logic [31:0] trial;
        t_sqrt_state r;
        sh    = 5'd30 - {k, 1'b0};
        bitv  = 32'd1 << sh;
        trial = s.root + bitv;
        if (s.rem >= trial) begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/rfam_geom.sv -----
// Canvas geometry stages: canvas size, offsets from centre, squares, sum.
// Depends on rfam_pkg.
`timescale 1ns / 1ps

module rfam_geom (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_pos_x,
    input  logic [7:0]          i_pos_y,
    input  logic [31:0]         i_src_colour,
    input  logic [14:0]         i_outer,
    output logic                o_valid,
    input  logic                i_ready,
    output rfam_pkg::t_dist_item o_item
);

    logic [8:0]         w_size_raw;
    logic [8:0]         w_size;
    logic               w_off;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic [15:0]        w_ax;
    logic [15:0]        w_ay;
    logic               w_ready1;
    logic               w_ready2;
    logic               w_ready3;

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [15:0]        r_ax;
    logic [15:0]        r_ay;
    logic               r_off1;
    logic [31:0]        r_col1;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic               r_off2;
    logic [31:0]        r_col2;
    logic [31:0]        r_sum;
    logic               r_off3;
    logic [31:0]        r_col3;

    always_comb begin
        w_size_raw = 9'(({1'b0, i_outer, 1'b0} + 17'd255) >> 8) + 9'd2;
        w_size     = (w_size_raw > rfam_pkg::MAX_CANVAS) ? rfam_pkg::MAX_CANVAS : w_size_raw;
        w_off      = ({1'b0, i_pos_x} >= w_size) || ({1'b0, i_pos_y} >= w_size);
        w_dx       = $signed({1'b0, i_pos_x, 8'h80}) - $signed({1'b0, w_size, 7'd0});
        w_dy       = $signed({1'b0, i_pos_y, 8'h80}) - $signed({1'b0, w_size, 7'd0});
        w_ax       = w_dx[16] ? 16'(-w_dx) : w_dx[15:0];
        w_ay       = w_dy[16] ? 16'(-w_dy) : w_dy[15:0];
        w_ready3   = !r_v3 || i_ready;
        w_ready2   = !r_v2 || w_ready3;
        w_ready1   = !r_v1 || w_ready2;
    end

    assign o_ready = w_ready1;
    assign o_valid = r_v3;
    assign o_item  = '{off: r_off3, colour: r_col3, sq_sum: r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ready1) r_v1 <= i_valid;
            if (w_ready2) r_v2 <= r_v1;
            if (w_ready3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r_ax   <= w_ax;
            r_ay   <= w_ay;
            r_off1 <= w_off;
            r_col1 <= i_src_colour;
        end
        if (w_ready2 && r_v1) begin
            r_sqx  <= 32'(r_ax) * 32'(r_ax);
            r_sqy  <= 32'(r_ay) * 32'(r_ay);
            r_off2 <= r_off1;
            r_col2 <= r_col1;
        end
        if (w_ready3 && r_v2) begin
            r_sum  <= r_sqx + r_sqy;
            r_off3 <= r_off2;
            r_col3 <= r_col2;
        end
    end

endmodule

// ----- hdl/rfam_sqrt.sv -----
// Pipelined integer square root of the squared distance, two digits a stage.
// Depends on rfam_pkg.
`timescale 1ns / 1ps

module rfam_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rfam_pkg::t_dist_item i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rfam_pkg::t_root_item o_item
);

    localparam int NS = rfam_pkg::SQRT_STAGES;

    logic [NS-1:0]        w_ready;
    logic [NS-1:0]        w_in_vld;
    rfam_pkg::t_sqrt_item w_in   [NS];
    rfam_pkg::t_sqrt_item w_next [NS];

    logic [NS-1:0]        r_vld;
    rfam_pkg::t_sqrt_item r_item [NS];

    always_comb begin
        rfam_pkg::t_sqrt_state v_st;
        w_in[0]     = '{off: i_item.off, colour: i_item.colour,
                        st: '{rem: i_item.sq_sum, root: 32'd0}};
        w_in_vld[0] = i_valid;
        for (int j = 1; j < NS; j++) begin
            w_in[j]     = r_item[j-1];
            w_in_vld[j] = r_vld[j-1];
        end
        w_ready[NS-1] = !r_vld[NS-1] || i_ready;
        for (int j = NS - 2; j >= 0; j--) begin
            w_ready[j] = !r_vld[j] || w_ready[j+1];
        end
        for (int j = 0; j < NS; j++) begin
            v_st = w_in[j].st;
            for (int k = 0; k < rfam_pkg::SQRT_ITER_STAGE; k++) begin
                v_st = rfam_pkg::sqrt_step(v_st, 4'(j * rfam_pkg::SQRT_ITER_STAGE + k));
            end
            w_next[j]    = w_in[j];
            w_next[j].st = v_st;
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_vld[NS-1];
    assign o_item  = '{off: r_item[NS-1].off, colour: r_item[NS-1].colour,
                       root: r_item[NS-1].st.root[15:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < NS; j++) begin
                if (w_ready[j]) r_vld[j] <= w_in_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NS; j++) begin
            if (w_ready[j] && w_in_vld[j]) r_item[j] <= w_next[j];
        end
    end

endmodule

// ----- hdl/rfam_blend.sv -----
// Ramp factor and alpha scaling stages, producing the masked colour.
// Depends on rfam_pkg.
`timescale 1ns / 1ps

module rfam_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rfam_pkg::t_root_item i_item,
    input  logic [14:0]          i_outer,
    input  logic [14:0]          i_inner,
    input  logic [24:0]          i_gain,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_colour
);

    logic        w_full;
    logic        w_zero;
    logic [14:0] w_diff;
    logic [24:0] w_f;
    logic        w_kill_b;
    logic [32:0] w_round;
    logic        w_ready_a;
    logic        w_ready_b;
    logic        w_ready_c;

    logic        r_va;
    logic        r_vb;
    logic        r_vc;
    logic        r_full_a;
    logic        r_kill_a;
    logic [39:0] r_prod_a;
    logic [31:0] r_col_a;
    logic        r_kill_b;
    logic [32:0] r_amul_b;
    logic [23:0] r_rgb_b;
    logic [31:0] r_out;

    always_comb begin
        w_full    = i_item.root <= {1'b0, i_inner};
        w_zero    = i_item.root >= {1'b0, i_outer};
        w_diff    = i_outer - i_item.root[14:0];
        w_f       = r_full_a ? rfam_pkg::ONE_Q24 :
                    ((r_prod_a > 40'(rfam_pkg::ONE_Q24)) ? rfam_pkg::ONE_Q24 : r_prod_a[24:0]);
        w_kill_b  = r_kill_a || (w_f == 25'd0);
        w_round   = r_amul_b + rfam_pkg::HALF_Q24;
        w_ready_c = !r_vc || i_ready;
        w_ready_b = !r_vb || w_ready_c;
        w_ready_a = !r_va || w_ready_b;
    end

    assign o_ready  = w_ready_a;
    assign o_valid  = r_vc;
    assign o_colour = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_ready_a) r_va <= i_valid;
            if (w_ready_b) r_vb <= r_va;
            if (w_ready_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_full_a <= w_full;
            r_kill_a <= i_item.off || (!w_full && w_zero);
            r_prod_a <= 40'(w_diff) * 40'(i_gain);
            r_col_a  <= i_item.colour;
        end
        if (w_ready_b && r_va) begin
            r_kill_b <= w_kill_b;
            r_amul_b <= 33'(w_f) * 33'(r_col_a[31:24]);
            r_rgb_b  <= r_col_a[23:0];
        end
        if (w_ready_c && r_vb) begin
            r_out <= r_kill_b ? 32'd0 : {w_round[31:24], r_rgb_b};
        end
    end

endmodule

// ----- hdl/radial_feather_alpha_mask_top.sv -----
// Radial feathered alpha mask: takes one pixel per clock while not stalled, through
// 3 geometry stages, 8 square-root stages of two digits each and 3 blend stages.
// A stall holds the full pipeline; empty stages still fill while the output waits.
// Registers take effect at once; write them only while no pixel is in flight.
// Depends on rfam_pkg, rfam_geom, rfam_sqrt and rfam_blend.
`timescale 1ns / 1ps

module radial_feather_alpha_mask_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_pos_x,
    input  logic [7:0]               i_pos_y,
    input  logic [31:0]              i_src_colour,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [31:0]              o_out_colour,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  rfam_pkg::t_cfg_index     i_cfg_index,
    input  logic [24:0]              i_cfg_data
);

    logic [14:0]          r_outer;
    logic [14:0]          r_inner;
    logic [24:0]          r_gain;
    logic [14:0]          w_outer_eff;
    logic                 w_in_ready;
    logic                 w_geom_valid;
    logic                 w_geom_ready;
    rfam_pkg::t_dist_item w_geom_item;
    logic                 w_sqrt_valid;
    logic                 w_sqrt_ready;
    rfam_pkg::t_root_item w_sqrt_item;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !w_in_ready;
    assign w_outer_eff = (r_outer < rfam_pkg::OUTER_MIN) ? rfam_pkg::OUTER_MIN : r_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer <= rfam_pkg::OUTER_RESET;
            r_inner <= rfam_pkg::INNER_RESET;
            r_gain  <= rfam_pkg::GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rfam_pkg::CFG_OUTER_RADIUS: r_outer <= i_cfg_data[14:0];
                rfam_pkg::CFG_INNER_RADIUS: r_inner <= i_cfg_data[14:0];
                rfam_pkg::CFG_RAMP_GAIN:    r_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rfam_geom u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (w_in_ready),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_src_colour (i_src_colour),
        .i_outer      (w_outer_eff),
        .o_valid      (w_geom_valid),
        .i_ready      (w_geom_ready),
        .o_item       (w_geom_item)
    );

    rfam_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_geom_valid),
        .o_ready (w_geom_ready),
        .i_item  (w_geom_item),
        .o_valid (w_sqrt_valid),
        .i_ready (w_sqrt_ready),
        .o_item  (w_sqrt_item)
    );

    rfam_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_sqrt_valid),
        .o_ready  (w_sqrt_ready),
        .i_item   (w_sqrt_item),
        .i_outer  (w_outer_eff),
        .i_inner  (r_inner),
        .i_gain   (r_gain),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_colour (o_out_colour)
    );

endmodule

// ----- hdl/rfam_checker.sv -----
// Port-level checker for the radial feather alpha mask, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfam_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_colour
);

    `RFAM_ASSERT_NXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_valid)
    `RFAM_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `RFAM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_colour))
    `RFAM_ASSERT_IMP(a_drop_after_xfer, i_clk, i_rst_n, $fell(o_valid), $past(!i_stall))

endmodule

bind radial_feather_alpha_mask_top rfam_checker u_rfam_checker (.*);
